// ----- hw/rtl/pnz_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the plane-normal-to-z rotation block.
// No dependencies; every design file in hw/rtl except pnz_if imports this package.
package pnz_pkg;

  localparam int unsigned CORDIC_W = 40;  // signed CORDIC datapath, Q.28 with headroom
  localparam int unsigned DIV_QW   = 32;  // quotient bits per divider
  localparam int unsigned DIV1_W   = 72;  // remainder width, divide by magnitude
  localparam int unsigned DIV2_W   = 66;  // remainder width, divide by 1 + cos

  localparam logic signed [CORDIC_W-1:0] ONE_Q28 = CORDIC_W'(64'd268435456);
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  typedef struct packed {
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] plane_offset;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic signed [31:0] plane_depth;
    logic               degenerate;
  } out_t;

  // Travels with an item through both CORDIC chains and the first divider.
  typedef struct packed {
    logic        deg;
    logic        neg0;
    logic        neg1;
    logic        neg2;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
  } side1_t;

  // Travels with an item through the second divider.
  typedef struct packed {
    logic        deg;
    logic        neg0;
    logic        neg1;
    logic        neg2;
    logic [31:0] c;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] m2;
    logic [63:0] dprod;
  } side2_t;

  // Vectoring CORDIC magnitude of (x0, 0), evaluated at elaboration for the gain constants.
  function automatic logic signed [CORDIC_W-1:0] cordic_mag_const(
    input logic signed [CORDIC_W-1:0] x0,
    input int stages
  );
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    x = x0;
    y = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < stages) begin
        dx = y >>> i;
        dy = x >>> i;
        if (!y[CORDIC_W-1]) begin
          x = x + dx;
          y = y - dy;
        end else begin
          x = x - dx;
          y = y + dy;
        end
      end
    end
    return x;
  endfunction

  function automatic logic signed [34:0] apply_sign(input logic neg,
                                                    input logic signed [34:0] mag);
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/pnz_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
// Payload type is supplied by the instantiating level (types from pnz_pkg).
interface pnz_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/plane_normal_to_z_rotation_top.sv -----
// Rotation that turns a fitted plane's normal onto the z axis, plus the plane depth.
// Uses pnz_pkg, pnz_if, pnz_cordic_cell and pnz_div_cell.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+------------
//   in_i     | in  | slope_x, slope_y, plane_offset            | valid/ready
//   out_o    | out | r00..r22, plane_depth, degenerate         | valid/ready
//
// One transaction enters every cycle while the output is not stalled; the pipe is two CORDIC
// chains of CORDIC_STAGES cells, two 32-cell divider chains and the p1, pst, p2 and output registers.
// The whole pipe advances when the output register is empty or being taken, so a
// stalled output holds every stage and in_i.ready drops with it.
// Reset clears all valid bits; no clearing pass.
module plane_normal_to_z_rotation_top #(
  parameter int CORDIC_STAGES = 24
) (
  input logic clk_i,
  input logic rst_ni,
  pnz_if.sink   in_i,
  pnz_if.source out_o
);
  import pnz_pkg::*;

  localparam int S  = CORDIC_STAGES;
  localparam int CW = CORDIC_W;
  localparam int QW = DIV_QW;
  localparam int W1 = DIV1_W;
  localparam int W2 = DIV2_W;
  localparam logic signed [CW-1:0] G1 = cordic_mag_const(ONE_Q28, S);
  localparam logic signed [CW-1:0] GN = cordic_mag_const(G1, S);

  logic adv;
  logic out_valid_q;
  out_t out_data_q;

  assign adv       = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // ---- input magnitudes and signs
  in_t    din;
  side1_t s_in;

  always_comb begin
    din        = in_i.data;
    s_in.neg0  = din.slope_x[31];
    s_in.neg1  = din.slope_y[31];
    s_in.neg2  = din.plane_offset[31];
    s_in.m0    = s_in.neg0 ? unsigned'(-din.slope_x) : unsigned'(din.slope_x);
    s_in.m1    = s_in.neg1 ? unsigned'(-din.slope_y) : unsigned'(din.slope_y);
    s_in.m2    = s_in.neg2 ? unsigned'(-din.plane_offset) : unsigned'(din.plane_offset);
    s_in.deg   = (din.slope_x == '0);
  end

  // ---- CORDIC chain 1: |(a0, a1)|
  logic                c1_v [0:S];
  logic signed [CW-1:0] c1_x [0:S];
  logic signed [CW-1:0] c1_y [0:S];
  side1_t              c1_s [0:S];

  assign c1_v[0] = in_i.valid;
  assign c1_x[0] = $signed(CW'({s_in.m0, 4'b0}));
  assign c1_y[0] = $signed(CW'({s_in.m1, 4'b0}));
  assign c1_s[0] = s_in;

  // ---- CORDIC chain 2: |(x1, 1)|
  logic                c2_v [0:S];
  logic signed [CW-1:0] c2_x [0:S];
  logic signed [CW-1:0] c2_y [0:S];
  side1_t              c2_s [0:S];

  assign c2_v[0] = c1_v[S];
  assign c2_x[0] = c1_x[S];
  assign c2_y[0] = G1;
  assign c2_s[0] = c1_s[S];

  for (genvar k = 0; k < S; k++) begin : g_cordic
    pnz_cordic_cell #(.SHIFT(k), .side_t(side1_t)) u_c1 (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(c1_v[k]), .x_i(c1_x[k]), .y_i(c1_y[k]), .side_i(c1_s[k]),
      .valid_o(c1_v[k+1]), .x_o(c1_x[k+1]), .y_o(c1_y[k+1]), .side_o(c1_s[k+1])
    );
    pnz_cordic_cell #(.SHIFT(k), .side_t(side1_t)) u_c2 (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(c2_v[k]), .x_i(c2_x[k]), .y_i(c2_y[k]), .side_i(c2_s[k]),
      .valid_o(c2_v[k+1]), .x_o(c2_x[k+1]), .y_o(c2_y[k+1]), .side_o(c2_s[k+1])
    );
  end

  // ---- numerators for c, s0, s1
  logic          p1_v_q;
  logic [W1-1:0] p1_n_q [3];
  logic [W1-1:0] p1_den_q;
  side1_t        p1_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= c2_v[S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_n_q[0] <= W1'(GN[29:0]) << 30;
      p1_n_q[1] <= (W1'(c2_s[S].m0) * W1'(GN[29:0])) << 6;
      p1_n_q[2] <= (W1'(c2_s[S].m1) * W1'(GN[29:0])) << 6;
      p1_den_q  <= W1'($unsigned(c2_x[S]));
      p1_s_q    <= c2_s[S];
    end
  end

  // ---- divider chain 1: divide by x2
  logic          d1_v [0:QW];
  logic [W1-1:0] d1_r [0:QW][3];
  logic [QW-1:0] d1_q [0:QW][3];
  logic [W1-1:0] d1_d [0:QW];
  side1_t        d1_s [0:QW];

  assign d1_v[0] = p1_v_q;
  assign d1_r[0] = p1_n_q;
  assign d1_q[0] = '{default: '0};
  assign d1_d[0] = p1_den_q;
  assign d1_s[0] = p1_s_q;

  for (genvar k = 0; k < QW; k++) begin : g_div1
    pnz_div_cell #(.BIT(QW-1-k), .W(W1), .LANES(3), .side_t(side1_t)) u_d1 (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(d1_v[k]), .rem_i(d1_r[k]), .quo_i(d1_q[k]), .den_i(d1_d[k]),
      .side_i(d1_s[k]),
      .valid_o(d1_v[k+1]), .rem_o(d1_r[k+1]), .quo_o(d1_q[k+1]), .den_o(d1_d[k+1]),
      .side_o(d1_s[k+1])
    );
  end

  // ---- round to c, s0, s1
  logic [32:0] q1r [3];
  side2_t      pst_d;
  logic        pst_v_q;
  side2_t      pst_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q1r[l] = 33'(d1_q[QW][l])
             + 33'({d1_r[QW][l], 1'b0} >= {1'b0, d1_d[QW]});
    end
    pst_d.deg   = d1_s[QW].deg;
    pst_d.neg0  = d1_s[QW].neg0;
    pst_d.neg1  = d1_s[QW].neg1;
    pst_d.neg2  = d1_s[QW].neg2;
    pst_d.c     = q1r[0][31:0];
    pst_d.s0    = q1r[1][31:0];
    pst_d.s1    = q1r[2][31:0];
    pst_d.m2    = d1_s[QW].m2;
    pst_d.dprod = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_v_q <= 1'b0;
    end else if (adv) begin
      pst_v_q <= d1_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pst_q <= pst_d;
    end
  end

  // ---- products and h = 1 + c
  logic          p2_v_q;
  logic [W2-1:0] p2_n_q [3];
  logic [W2-1:0] p2_den_q;
  side2_t        p2_s_d;
  side2_t        p2_s_q;

  always_comb begin
    p2_s_d       = pst_q;
    p2_s_d.dprod = 64'(pst_q.m2) * 64'(pst_q.c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (adv) begin
      p2_v_q <= pst_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_n_q[0]    <= W2'(64'(pst_q.s0) * 64'(pst_q.s0));
      p2_n_q[1]    <= W2'(64'(pst_q.s1) * 64'(pst_q.s1));
      p2_n_q[2]    <= W2'(64'(pst_q.s0) * 64'(pst_q.s1));
      p2_den_q     <= W2'(pst_q.c) + W2'(ONE_Q30);
      p2_s_q       <= p2_s_d;
    end
  end

  // ---- divider chain 2: divide by h
  logic          d2_v [0:QW];
  logic [W2-1:0] d2_r [0:QW][3];
  logic [QW-1:0] d2_q [0:QW][3];
  logic [W2-1:0] d2_d [0:QW];
  side2_t        d2_s [0:QW];

  assign d2_v[0] = p2_v_q;
  assign d2_r[0] = p2_n_q;
  assign d2_q[0] = '{default: '0};
  assign d2_d[0] = p2_den_q;
  assign d2_s[0] = p2_s_q;

  for (genvar k = 0; k < QW; k++) begin : g_div2
    pnz_div_cell #(.BIT(QW-1-k), .W(W2), .LANES(3), .side_t(side2_t)) u_d2 (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(d2_v[k]), .rem_i(d2_r[k]), .quo_i(d2_q[k]), .den_i(d2_d[k]),
      .side_i(d2_s[k]),
      .valid_o(d2_v[k+1]), .rem_o(d2_r[k+1]), .quo_o(d2_q[k+1]), .den_o(d2_d[k+1]),
      .side_o(d2_s[k+1])
    );
  end

  // ---- assemble the matrix
  logic [32:0]        q2r [3];
  side2_t             fs;
  logic [64:0]        dsum;
  logic signed [34:0] c_v, e01, e02, e12, dep;
  out_t               o_d;

  always_comb begin
    fs = d2_s[QW];
    for (int l = 0; l < 3; l++) begin
      q2r[l] = 33'(d2_q[QW][l])
             + 33'({d2_r[QW][l], 1'b0} >= {1'b0, d2_d[QW]});
    end
    c_v  = $signed({3'b0, fs.c});
    e02  = apply_sign(fs.neg0, $signed({3'b0, fs.s0}));
    e12  = apply_sign(fs.neg1, $signed({3'b0, fs.s1}));
    // same-sign slopes give a negative cross term
    e01  = apply_sign(fs.neg0 == fs.neg1, $signed({2'b0, q2r[2]}));
    dsum = 65'(fs.dprod) + 65'(HALF_Q30);
    dep  = apply_sign(fs.neg2, $signed({1'b0, dsum[63:30]}));

    o_d.r00         = sat32(c_v + $signed({2'b0, q2r[1]}));
    o_d.r01         = sat32(e01);
    o_d.r02         = sat32(e02);
    o_d.r10         = sat32(e01);
    o_d.r11         = sat32(c_v + $signed({2'b0, q2r[0]}));
    o_d.r12         = sat32(e12);
    o_d.r20         = sat32(-e02);
    o_d.r21         = sat32(-e12);
    o_d.r22         = sat32(c_v);
    o_d.plane_depth = sat32(dep);
    o_d.degenerate  = 1'b0;
    if (fs.deg) begin
      o_d            = '0;
      o_d.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d2_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= o_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---- assertions
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.degenerate |->
      out_data_q.r00 == '0 && out_data_q.r22 == '0 && out_data_q.plane_depth == '0)
    else $error("degenerate result carries nonzero fields");

  a_r22_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.degenerate |-> !out_data_q.r22[31])
    else $error("r22 negative");

endmodule

// ----- hw/rtl/pnz_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation with its own pipeline register.
// Uses pnz_pkg for the datapath width.
module pnz_cordic_cell #(
  parameter int  SHIFT  = 0,
  parameter type side_t = logic
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [pnz_pkg::CORDIC_W-1:0]   x_i,
  input  logic signed [pnz_pkg::CORDIC_W-1:0]   y_i,
  input  side_t                                 side_i,
  output logic                                  valid_o,
  output logic signed [pnz_pkg::CORDIC_W-1:0]   x_o,
  output logic signed [pnz_pkg::CORDIC_W-1:0]   y_o,
  output side_t                                 side_o
);
  import pnz_pkg::*;

  logic signed [CORDIC_W-1:0] x_d, y_d;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic valid_q;
  logic signed [CORDIC_W-1:0] x_q, y_q;
  side_t side_q;

  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    // rotate toward the x axis
    if (!y_i[CORDIC_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;
endmodule

// ----- hw/rtl/pnz_div_cell.sv -----
// One restoring-division step for several numerators sharing one divisor.
// Settles quotient bit BIT; uses pnz_pkg for the quotient width.
module pnz_div_cell #(
  parameter int  BIT    = 0,
  parameter int  W      = 72,
  parameter int  LANES  = 3,
  parameter type side_t = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [W-1:0]                rem_i [LANES],
  input  logic [pnz_pkg::DIV_QW-1:0]  quo_i [LANES],
  input  logic [W-1:0]                den_i,
  input  side_t                       side_i,
  output logic                        valid_o,
  output logic [W-1:0]                rem_o [LANES],
  output logic [pnz_pkg::DIV_QW-1:0]  quo_o [LANES],
  output logic [W-1:0]                den_o,
  output side_t                       side_o
);
  import pnz_pkg::*;

  logic [W-1:0]      den_sh;
  logic [W:0]        trial [LANES];
  logic [W-1:0]      rem_d [LANES];
  logic [DIV_QW-1:0] quo_d [LANES];
  logic              valid_q;
  logic [W-1:0]      rem_q [LANES];
  logic [DIV_QW-1:0] quo_q [LANES];
  logic [W-1:0]      den_q;
  side_t             side_q;

  always_comb begin
    den_sh = den_i << BIT;
    for (int l = 0; l < LANES; l++) begin
      trial[l] = {1'b0, rem_i[l]} - {1'b0, den_sh};
      quo_d[l] = quo_i[l];
      // keep the difference only when no borrow
      quo_d[l][BIT] = ~trial[l][W];
      rem_d[l] = trial[l][W] ? rem_i[l] : trial[l][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;
endmodule

// ----- tb/plane_normal_to_z_rotation_top_test.sv -----
// Self-checking testbench for plane_normal_to_z_rotation_top: directed table, then random planes.
// Depends on pnz_pkg and pnz_if; expected results come from a predictor of the block in this file.
module plane_normal_to_z_rotation_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pnz_pkg::*;

  localparam int STAGES      = 24;
  localparam int LATENCY     = 2 * STAGES + 2 * 32 + 4;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    in_t  plane;
    bit   literal;
    out_t result;
  } plane_row_t;

  logic clk_i;
  logic rst_ni;

  pnz_if #(.payload_t(in_t))  in_ch ();
  pnz_if #(.payload_t(out_t)) out_ch ();

  plane_normal_to_z_rotation_top #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  out_t rotations_due[$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   holdoff_toggle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Vectoring CORDIC magnitude, gain left in.
  function automatic longint vec_mag(longint x, longint y);
    longint dx;
    longint dy;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    return x;
  endfunction

  // round(n * 2^k / d), halves rounded up
  function automatic longint unsigned quot_round(longint unsigned n, longint unsigned d, int k);
    longint unsigned q;
    longint unsigned r;
    if (d == 0) return 0;
    q = n / d;
    r = n % d;
    for (int i = 0; i < k; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
    end
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_t rotation_for(in_t p);
    longint a0;
    longint a1;
    longint a2;
    longint unsigned m0, m1, m2, gn, x2, c, s0, s1, h, q00, q11, q01, dmag;
    longint x1, g1, e01, e02, e12, depth;
    out_t r;
    r = '0;
    a0 = p.slope_x;
    a1 = p.slope_y;
    a2 = p.plane_offset;
    if (a0 == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    m0 = a0 < 0 ? -a0 : a0;
    m1 = a1 < 0 ? -a1 : a1;
    m2 = a2 < 0 ? -a2 : a2;
    x1 = vec_mag(longint'(m0 << 4), longint'(m1 << 4));
    g1 = vec_mag(64'sd1 << 28, 0);
    x2 = vec_mag(x1, g1);
    gn = vec_mag(g1, 0);
    c   = quot_round(gn, x2, 30);
    s0  = quot_round(m0 * gn, x2, 6);
    s1  = quot_round(m1 * gn, x2, 6);
    h   = (64'd1 << 30) + c;
    q00 = quot_round(s0 * s0, h, 0);
    q11 = quot_round(s1 * s1, h, 0);
    q01 = quot_round(s0 * s1, h, 0);
    e02 = a0 < 0 ? -longint'(s0) : longint'(s0);
    e12 = a1 < 0 ? -longint'(s1) : longint'(s1);
    e01 = ((a0 < 0) == (a1 < 0)) ? -longint'(q01) : longint'(q01);
    dmag = (m2 * c + (64'd1 << 29)) >> 30;
    depth = a2 < 0 ? -longint'(dmag) : longint'(dmag);
    r.r00 = clamp32(longint'(c + q11));
    r.r01 = clamp32(e01);
    r.r02 = clamp32(e02);
    r.r10 = clamp32(e01);
    r.r11 = clamp32(longint'(c + q00));
    r.r12 = clamp32(e12);
    r.r20 = clamp32(-e02);
    r.r21 = clamp32(-e12);
    r.r22 = clamp32(longint'(c));
    r.plane_depth = clamp32(depth);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic compare_field(string what, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic compare_rotation(out_t got, out_t want);
    compare_field("r00", got.r00, want.r00);
    compare_field("r01", got.r01, want.r01);
    compare_field("r02", got.r02, want.r02);
    compare_field("r10", got.r10, want.r10);
    compare_field("r11", got.r11, want.r11);
    compare_field("r12", got.r12, want.r12);
    compare_field("r20", got.r20, want.r20);
    compare_field("r21", got.r21, want.r21);
    compare_field("r22", got.r22, want.r22);
    compare_field("plane_depth", got.plane_depth, want.plane_depth);
    if (got.degenerate !== want.degenerate)
      report_mismatch("degenerate", got.degenerate, want.degenerate);
  endtask

  // Offer one transaction, idling at random first; queue its expectation on acceptance.
  task automatic send_plane(in_t p, out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    rotations_due.push_back(want);
  endtask

  function automatic logic [31:0] random_slope();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(4095)) - 2048);
      2: return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  // Receiver: check each result, then decide ready for the next cycle.
  initial begin
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (rotations_due.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          compare_rotation(out_ch.data, rotations_due.pop_front());
        end
      end
      if (holdoff_toggle != hold_seen) begin
        hold_seen = holdoff_toggle;
        hold_left = 3 * LATENCY;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    plane_row_t rows[$];
    plane_row_t row;
    out_t       zero_deg;
    in_t        p;
    zero_deg = '0;
    zero_deg.degenerate = 1'b1;
    mismatches = 0;
    holdoff_toggle = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 59;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_ni = 1'b0;
    // zero slope_x is degenerate: all zeros whatever the other fields
    rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, zero_deg});
    rows.push_back('{'{32'sd0, 32'sh7fffffff, 32'sh7fffffff}, 1'b1, zero_deg});
    rows.push_back('{'{32'sd0, 32'sh80000000, 32'sh80000000}, 1'b1, zero_deg});
    rows.push_back('{'{32'sd0, -32'sd1, -32'sd1}, 1'b1, zero_deg});
    rows.push_back('{'{32'sh01000000, 32'sd0, 32'sh00010000}, 1'b0, zero_deg});
    rows.push_back('{'{-32'sh01000000, 32'sd0, -32'sh00010000}, 1'b0, zero_deg});
    rows.push_back('{'{32'sd1, 32'sd0, 32'sh7fffffff}, 1'b0, zero_deg});
    rows.push_back('{'{-32'sd1, 32'sd1, 32'sh80000000}, 1'b0, zero_deg});
    rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 1'b0, zero_deg});
    rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, zero_deg});
    rows.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sd0}, 1'b0, zero_deg});
    rows.push_back('{'{32'sh80000000, 32'sh7fffffff, -32'sd1}, 1'b0, zero_deg});
    rows.push_back('{'{32'sd1, 32'sh7fffffff, 32'sh00010000}, 1'b0, zero_deg});
    rows.push_back('{'{-32'sd1, 32'sh80000000, 32'sh12345678}, 1'b0, zero_deg});
    rows.push_back('{'{32'sh00400000, -32'sh00800000, 32'shfedcba98}, 1'b0, zero_deg});
    rows.push_back('{'{-32'sh00400000, 32'sh00800000, 32'sh00000001}, 1'b0, zero_deg});
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_plane(row.plane, row.literal ? row.result : rotation_for(row.plane));
    end
    // pause until the pipe has drained
    in_ch.valid <= 1'b0;
    wait (rotations_due.size() == 0);
    @(posedge clk_i);

    // long receiver hold-off while the sender keeps offering: pipe fills, input stalls
    holdoff_toggle <= 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 36;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      p.slope_x      = ($urandom_range(19) == 0) ? 32'd0 : random_slope();
      p.slope_y      = random_slope();
      p.plane_offset = $urandom_range(3) == 0 ? random_slope() : $urandom();
      send_plane(p, rotation_for(p));
    end
    in_ch.valid <= 1'b0;

    wait (rotations_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && rotations_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
